### hw/rtl/rlbk_pkg.sv
// shared types, ladder levels and codes for the resistor ladder braille keypad
package rlbk_pkg;

   localparam int ADC_BITS_DEFAULT = 10;
   localparam int LEVEL_BITS = 10;
   localparam int NUM_LEVELS = 18;
   localparam int TOL_BITS = 4;
   localparam int DOT_BITS = 3;
   localparam int COL_BITS = 2;
   localparam int PATTERN_BITS = 6;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS = 4;
   localparam logic [TOL_BITS-1:0] TOL_RESET = 4'd2;

   typedef logic [LEVEL_BITS-1:0] level_type;
   typedef logic [DOT_BITS-1:0] dot_type;
   typedef logic [COL_BITS-1:0] col_type;
   typedef logic [PATTERN_BITS-1:0] pattern_type;

   // ladder voltages in adc counts, three cells of six dots
   localparam level_type LADDER_LEVEL [NUM_LEVELS] = '{
      10'h033, 10'h048, 10'h05D, 10'h0BE, 10'h0B2, 10'h0C8,
      10'h187, 10'h19C, 10'h191, 10'h206, 10'h21B, 10'h211,
      10'h2E7, 10'h2FD, 10'h2F2, 10'h352, 10'h373, 10'h37E
   };

   // every third level sits on the bottom row ladder
   localparam logic [NUM_LEVELS-1:0] LEVEL_ON_BOTTOM = 18'b100100100100100100;

   localparam dot_type LEVEL_DOT [NUM_LEVELS] = '{
      3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
      3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
      3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6
   };

   localparam col_type LEVEL_COLUMN [NUM_LEVELS] = '{
      2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
      2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
      2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3
   };

   localparam dot_type DOT_HALF = 3'd3;

   typedef enum logic [1:0] {
      MSG_DOT     = 2'd0,
      MSG_ECHO    = 2'd1,
      MSG_CAPTURE = 2'd2
   } msg_kind_type;

   typedef enum logic {
      REQ_SAMPLE  = 1'b0,
      REQ_CAPTURE = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_INTERFACE_MODE  = 1'd0,
      CSR_MATCH_TOLERANCE = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic    found;
      dot_type dot;
      col_type col;
   } decode_type;

   // one queued result record; a press expands to a dot and an echo beat
   typedef struct packed {
      logic        capture;
      dot_type     dot;
      col_type     col;
      pattern_type pattern;
   } record_type;

endpackage

### hw/rtl/rlbk_decode.sv
// parallel window compare against the ladder levels and dot/column decode
module rlbk_decode #(
   parameter int ADC_BITS = rlbk_pkg::ADC_BITS_DEFAULT
) (
   input  logic [ADC_BITS-1:0]            adc_top,
   input  logic [ADC_BITS-1:0]            adc_bottom,
   input  logic [rlbk_pkg::TOL_BITS-1:0]  tolerance,
   input  logic                           mirror,
   output rlbk_pkg::decode_type           result
);
   import rlbk_pkg::*;

   localparam int CmpBits = ADC_BITS + 1;

   logic [CmpBits-1:0] top_ext;
   logic [CmpBits-1:0] bot_ext;
   logic [CmpBits-1:0] tol_ext;

   assign top_ext = CmpBits'(adc_top);
   assign bot_ext = CmpBits'(adc_bottom);
   assign tol_ext = CmpBits'(tolerance);

   always_comb begin
      logic [CmpBits-1:0] v;
      logic [CmpBits-1:0] lv;
      decode_type         d;
      d = '0;
      // later levels override earlier ones, so the last matching level in table order wins
      for (int i = 0; i < NUM_LEVELS; i++) begin
         v  = LEVEL_ON_BOTTOM[i] ? bot_ext : top_ext;
         lv = CmpBits'(LADDER_LEVEL[i]);
         if ((v + tol_ext >= lv) && (v <= lv + tol_ext)) begin
            d.found = 1'b1;
            d.dot   = LEVEL_DOT[i];
            d.col   = LEVEL_COLUMN[i];
         end
      end
      if (mirror) begin
         d.dot = (d.dot > DOT_HALF) ? d.dot - DOT_HALF : d.dot + DOT_HALF;
      end
      result = d;
   end

endmodule

### hw/rtl/resistor_ladder_braille_keypad_unit.sv
// top level of the resistor ladder braille keypad decoder
// Each sample transaction is decoded in the cycle it is accepted: 18 window compares,
// a priority pick and the dot store update are done combinationally and the result
// record goes into a two-entry output queue. A new dot press gives two result
// transactions (dot, then echo with last set), a capture gives one, and a sample
// with no match or a repeat of the last press gives none. Requests are taken in
// every cycle while the queue has room, so items with no result run at one per
// cycle and press items are bounded by the two result beats they each need.
// Configuration writes take effect on the next cycle and belong in idle time.
module resistor_ladder_braille_keypad_unit #(
   parameter int ADC_BITS = rlbk_pkg::ADC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_type,
   input  logic [ADC_BITS-1:0]                  req_adc_top,
   input  logic [ADC_BITS-1:0]                  req_adc_bottom,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output rlbk_pkg::msg_kind_type               rsp_msg_kind,
   output logic [rlbk_pkg::DOT_BITS-1:0]        rsp_dot_number,
   output logic [rlbk_pkg::COL_BITS-1:0]        rsp_column_number,
   output logic [rlbk_pkg::PATTERN_BITS-1:0]    rsp_cell_pattern,
   output logic                                 rsp_last,
   input  logic                                 csr_write_en,
   input  logic [rlbk_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rlbk_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import rlbk_pkg::*;

   localparam int QueueDepth = 2;
   localparam int PtrBits = $clog2(QueueDepth);
   localparam int CountBits = $clog2(QueueDepth + 1);

   logic                mode_ff, mode_in;
   logic [TOL_BITS-1:0] tol_ff, tol_in;
   pattern_type         dots_held_ff, dots_held_in;
   dot_type             last_dot_ff, last_dot_in;
   col_type             last_column_ff, last_column_in;

   record_type          queue_ff [QueueDepth];
   logic [PtrBits-1:0]  head_ff, head_in;
   logic [PtrBits-1:0]  tail_ff, tail_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic                phase_ff, phase_in;

   decode_type          dec;
   record_type          head_rec;
   record_type          push_rec;
   logic                req_fire;
   logic                rsp_fire;
   logic                push;
   logic                pop;

   rlbk_decode #(
      .ADC_BITS (ADC_BITS)
   ) u_decode (
      .adc_top    (req_adc_top),
      .adc_bottom (req_adc_bottom),
      .tolerance  (tol_ff),
      .mirror     (mode_ff),
      .result     (dec)
   );

   assign req_ready = (count_ff != CountBits'(QueueDepth));
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign head_rec  = queue_ff[head_ff];
   // a press record stays at the head until its echo beat is taken
   assign pop       = rsp_fire && (head_rec.capture || phase_ff);

   always_comb begin
      mode_in        = mode_ff;
      tol_in         = tol_ff;
      dots_held_in   = dots_held_ff;
      last_dot_in    = last_dot_ff;
      last_column_in = last_column_ff;
      push           = 1'b0;
      push_rec       = '0;

      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_INTERFACE_MODE:  mode_in = csr_wdata[0];
            CSR_MATCH_TOLERANCE: tol_in  = csr_wdata[TOL_BITS-1:0];
            default: ;
         endcase
      end

      if (req_fire) begin
         if (req_kind_type'(req_type) == REQ_CAPTURE) begin
            push             = 1'b1;
            push_rec.capture = 1'b1;
            push_rec.pattern = dots_held_ff;
            dots_held_in     = '0;
            last_dot_in      = '0;
         end else if (dec.found &&
                      !(dec.dot == last_dot_ff && dec.col == last_column_ff)) begin
            push           = 1'b1;
            push_rec.dot   = dec.dot;
            push_rec.col   = dec.col;
            last_dot_in    = dec.dot;
            last_column_in = dec.col;
            dots_held_in   = dots_held_ff |
                             PATTERN_BITS'(1 << (dec.dot - DOT_BITS'(1)));
         end
      end

      head_in  = pop  ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff + CountBits'(push) - CountBits'(pop);
      phase_in = phase_ff;
      if (rsp_fire) begin
         phase_in = head_rec.capture ? 1'b0 : !phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= 1'b0;
         tol_ff         <= TOL_RESET;
         dots_held_ff   <= '0;
         last_dot_ff    <= '0;
         last_column_ff <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         phase_ff       <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         tol_ff         <= tol_in;
         dots_held_ff   <= dots_held_in;
         last_dot_ff    <= last_dot_in;
         last_column_ff <= last_column_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         count_ff       <= count_in;
         phase_ff       <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[tail_ff] <= push_rec;
      end
   end

   always_comb begin
      if (head_rec.capture) begin
         rsp_msg_kind = MSG_CAPTURE;
      end else if (phase_ff) begin
         rsp_msg_kind = MSG_ECHO;
      end else begin
         rsp_msg_kind = MSG_DOT;
      end
   end

   assign rsp_dot_number    = head_rec.dot;
   assign rsp_column_number = head_rec.col;
   assign rsp_cell_pattern  = head_rec.pattern;
   assign rsp_last          = head_rec.capture || phase_ff;

endmodule

### hw/rtl/rlbk_checker.sv
// port level checks for the keypad decoder, bound to the top level
module rlbk_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input rlbk_pkg::msg_kind_type               rsp_msg_kind,
   input logic [rlbk_pkg::DOT_BITS-1:0]        rsp_dot_number,
   input logic [rlbk_pkg::COL_BITS-1:0]        rsp_column_number,
   input logic [rlbk_pkg::PATTERN_BITS-1:0]    rsp_cell_pattern,
   input logic                                 rsp_last
);
   import rlbk_pkg::*;

   // nothing to deliver right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_msg_kind) &&
         $stable(rsp_dot_number) && $stable(rsp_column_number) &&
         $stable(rsp_cell_pattern) && $stable(rsp_last))
      else $error("stalled result changed");

   // a dot message is always followed by its echo for the same press
   a_echo_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_msg_kind == MSG_DOT |=>
         rsp_valid && rsp_msg_kind == MSG_ECHO &&
         rsp_dot_number == $past(rsp_dot_number) &&
         rsp_column_number == $past(rsp_column_number))
      else $error("dot message not followed by matching echo");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last == (rsp_msg_kind != MSG_DOT))
      else $error("last flag does not match message kind");

endmodule

bind resistor_ladder_braille_keypad_unit rlbk_checker u_rlbk_checker (.*);
